>>> rtl/tprm_pkg.sv
// shared constants, word types and controller interface types for the pid rate monitor
`timescale 1ns / 1ps

package tprm_pkg;

  // store dimensions
  localparam int HISTORY_SLOTS = 64;
  localparam int PID_COUNT     = 8192;

  localparam int SLOT_W    = $clog2(HISTORY_SLOTS);
  localparam int PID_W     = $clog2(PID_COUNT);
  localparam int CELL_W    = SLOT_W + PID_W;
  localparam int SLOT_SPAN = 1 << SLOT_W;
  localparam int CELL_SPAN = 1 << CELL_W;

  // field widths
  localparam int OPC_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int QPID_W  = 13;
  localparam int QSLOT_W = 6;
  localparam int TOTAL_W = 32;
  localparam int COUNT_W = 16;
  localparam int INDEX_W = 6;
  localparam int PID_HI_W = QPID_W - BYTE_W;

  // range limits at comparison widths
  localparam logic [QPID_W:0]  PID_LIMIT  = (QPID_W + 1)'(PID_COUNT);
  localparam logic [8:0]       SLOT_LIMIT = 9'(HISTORY_SLOTS);
  localparam logic [PID_W-1:0] PID_LAST   = PID_W'(PID_COUNT - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_SLOTS - 1);

  typedef enum logic [OPC_W-1:0] {
    OP_PACKET = 2'd0,
    OP_TICK   = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [OPC_W-1:0]   opcode;
    logic [BYTE_W-1:0]  hdr_byte1;
    logic [BYTE_W-1:0]  hdr_byte2;
    logic [QPID_W-1:0]  query_pid;
    logic [QSLOT_W-1:0] query_slot;
  } in_word_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] pid_total;
    logic [COUNT_W-1:0] slot_count;
    logic [INDEX_W-1:0] slot_index;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // take the input word and read both stores
    logic update;     // write back and register the result
    logic sweep;      // clear one entry at the sweep counter
    logic sweep_tick; // sweep clears the next slot rather than the reset pass
    logic sweep_end;  // last entry of a sweep
  } tprm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
  } tprm_stat_t;

endpackage

>>> rtl/tprm_ctrl.sv
// controller state machine: reset clearing pass, item sequencing and slot sweeps
`timescale 1ns / 1ps

module tprm_ctrl
  import tprm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [OPC_W-1:0] opcode,
  input  tprm_stat_t       stat,
  output tprm_cmd_t        cmd,
  output logic             busy
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_SWEEP
  } state_t;

  state_t state;
  state_t state_next;

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          cmd.sweep_end = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = (opcode == OP_TICK) ? ST_SWEEP : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SWEEP: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_tick = 1'b1;
        if (stat.sweep_last) begin
          cmd.sweep_end = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/tprm_dp.sv
// datapath: total and slot count stores, slot index, sweep counter and result register
`timescale 1ns / 1ps

module tprm_dp
  import tprm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  in_word_t   item,
  input  tprm_cmd_t  cmd,
  output tprm_stat_t stat,
  output out_word_t  result,
  output logic       strobe
);

  // stores; a slot row whose valid bit is clear reads as zero
  logic [TOTAL_W-1:0] tot_mem [PID_COUNT];
  logic [COUNT_W-1:0] cnt_mem [CELL_SPAN];
  logic [SLOT_SPAN-1:0] slot_vld;

  logic [SLOT_W-1:0] cur_slot;
  logic [SLOT_W-1:0] slot_next;
  logic [PID_W-1:0]  sweep_cnt;

  // captured item
  logic [OPC_W-1:0]  op_q;
  logic              pid_ok_q;
  logic              slot_ok_q;
  logic              row_vld_q;
  logic [PID_W-1:0]  pid_q;
  logic [CELL_W-1:0] cell_q;
  logic [TOTAL_W-1:0] tot_rd;
  logic [COUNT_W-1:0] cnt_rd;

  // read side address decode
  logic [QPID_W-1:0]   hdr_pid;
  logic [QPID_W-1:0]   rd_pid13;
  logic [PID_W-1:0]    rd_pid;
  logic [SLOT_W-1:0]   rd_slot;
  logic [SLOT_W+QSLOT_W-1:0] qslot_ext;
  logic                rd_pid_ok;
  logic                rd_slot_ok;

  // write side
  logic               tot_we;
  logic [PID_W-1:0]   tot_wa;
  logic [TOTAL_W-1:0] tot_wd;
  logic               cnt_we;
  logic [CELL_W-1:0]  cnt_wa;
  logic [COUNT_W-1:0] cnt_wd;

  logic [TOTAL_W-1:0] tot_inc;
  logic [COUNT_W-1:0] cnt_inc;
  logic [SLOT_W+INDEX_W-1:0] idx_ext;
  logic [SLOT_W+INDEX_W-1:0] idx_next_ext;

  out_word_t res_next;

  // pid and slot selection for the read at capture
  always_comb begin
    hdr_pid    = {item.hdr_byte1[PID_HI_W-1:0], item.hdr_byte2};
    rd_pid13   = (item.opcode == OP_PACKET) ? hdr_pid : item.query_pid;
    rd_pid     = rd_pid13[PID_W-1:0];
    rd_pid_ok  = ({1'b0, rd_pid13} < PID_LIMIT);
    qslot_ext  = {{SLOT_W{1'b0}}, item.query_slot};
    rd_slot    = (item.opcode == OP_PACKET) ? cur_slot : qslot_ext[SLOT_W-1:0];
    rd_slot_ok = (item.opcode == OP_PACKET) ? 1'b1 : ({3'b0, item.query_slot} < SLOT_LIMIT);
  end

  // next slot, wrapping at the history depth
  assign slot_next = (cur_slot == SLOT_LAST) ? '0 : cur_slot + 1'b1;

  assign stat.sweep_last = (sweep_cnt == PID_LAST);

  // increments for a packet
  assign tot_inc = tot_rd + 1'b1;
  assign cnt_inc = (row_vld_q ? cnt_rd : '0) + 1'b1;

  // write port selection
  always_comb begin
    tot_we = 1'b0;
    tot_wa = pid_q;
    tot_wd = tot_inc;
    cnt_we = 1'b0;
    cnt_wa = cell_q;
    cnt_wd = cnt_inc;
    if (cmd.sweep) begin
      tot_we = !cmd.sweep_tick;
      tot_wa = sweep_cnt;
      tot_wd = '0;
      cnt_we = 1'b1;
      cnt_wa = {(cmd.sweep_tick ? slot_next : {SLOT_W{1'b0}}), sweep_cnt};
      cnt_wd = '0;
    end else if (cmd.update && (op_q == OP_PACKET) && pid_ok_q) begin
      tot_we = 1'b1;
      cnt_we = 1'b1;
    end
  end

  // total store
  always_ff @(posedge clk) begin
    if (tot_we) begin
      tot_mem[tot_wa] <= tot_wd;
    end
    if (cmd.capture) begin
      tot_rd <= tot_mem[rd_pid];
    end
  end

  // slot count store
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cmd.capture) begin
      cnt_rd <= cnt_mem[{rd_slot, rd_pid}];
    end
  end

  // captured item fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q      <= item.opcode;
      pid_ok_q  <= rd_pid_ok;
      slot_ok_q <= rd_slot_ok;
      row_vld_q <= slot_vld[rd_slot];
      pid_q     <= rd_pid;
      cell_q    <= {rd_slot, rd_pid};
    end
  end

  // result word for each opcode
  always_comb begin
    idx_ext      = {{INDEX_W{1'b0}}, cur_slot};
    idx_next_ext = {{INDEX_W{1'b0}}, slot_next};
    res_next     = '0;
    res_next.slot_index = idx_ext[INDEX_W-1:0];
    case (op_q)
      OP_PACKET: begin
        if (pid_ok_q) begin
          res_next.pid_total  = tot_inc;
          res_next.slot_count = cnt_inc;
        end
      end
      OP_READ: begin
        if (pid_ok_q) begin
          res_next.pid_total = tot_rd;
          if (slot_ok_q && row_vld_q) begin
            res_next.slot_count = cnt_rd;
          end
        end
      end
      default: begin
      end
    endcase
    if (cmd.sweep_tick) begin
      res_next            = '0;
      res_next.slot_index = idx_next_ext[INDEX_W-1:0];
    end
  end

  // result register, flagged for one cycle by strobe
  always_ff @(posedge clk) begin
    if (cmd.update || (cmd.sweep_end && cmd.sweep_tick)) begin
      result <= res_next;
    end
  end

  // control state: strobe, slot index, row valid bits, sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe    <= 1'b0;
      cur_slot  <= '0;
      slot_vld  <= '0;
      sweep_cnt <= '0;
    end else begin
      strobe <= cmd.update || (cmd.sweep_end && cmd.sweep_tick);
      if (cmd.sweep_end) begin
        sweep_cnt <= '0;
        if (cmd.sweep_tick) begin
          cur_slot            <= slot_next;
          slot_vld[slot_next] <= 1'b1;
        end else begin
          slot_vld[0] <= 1'b1;
        end
      end else if (cmd.sweep) begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end else if (cmd.capture) begin
        sweep_cnt <= '0;
      end
    end
  end

endmodule

>>> rtl/ts_pid_rate_monitor.sv
// top level: per-pid packet and per-slot counters for a transport stream
// packet, read and unused-code words: taken on start while idle, both stores read at capture,
//   write-back and result register loaded in the update step, then strobe; busy holds off a new word
// tick word: sweeps PID_COUNT slot entries, one per cycle, result strobed after the last entry
// reset: a clearing pass over PID_COUNT entries with busy high, then all counters read zero
// results are shown for one cycle on strobe; the receiver cannot stall
`timescale 1ns / 1ps

module ts_pid_rate_monitor
  import tprm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_word_t  item,
  output out_word_t result,
  output logic      strobe
);

  tprm_cmd_t  cmd;
  tprm_stat_t stat;

  // sequencing
  tprm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (item.opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // stores and arithmetic
  tprm_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result),
    .strobe (strobe)
  );

endmodule
